/* rtl/cscan_pkg.sv */
// Shared codes for the circular-scan disk scheduler.
// No dependencies; imported by the scheduler top level.
package cscan_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_HEAD  = 2'd0,
    CFG_DISK_TRACKS = 2'd1,
    CFG_SWEEP_UP    = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_START = 1'b1
  } cmd_e;

endpackage

/* rtl/cscan_disk_scheduler.sv */
// C-SCAN disk scheduler top level; uses cscan_pkg and cscan_store.
// A load word leaves busy low. A start word with n requests yields n results, each
// found by one compare unit passing over the store and added into the movement,
// with one pass of the edge and wrap states per run and busy high throughout;
// an empty start answers in the next cycle. Results cannot be stalled. Reset
// restores control, counts and registers; the store is not reset.
module cscan_disk_scheduler #(
  parameter int unsigned MAX_REQUESTS = 64,
  parameter int unsigned TRACK_BITS   = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                command_i,
  input  logic [TRACK_BITS-1:0]               track_i,
  input  logic                                cfg_we_i,
  input  logic [cscan_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [TRACK_BITS:0]                 cfg_wdata_i,
  output logic                                result_valid_o,
  output logic [TRACK_BITS-1:0]               served_track_o,
  output logic                                last_of_run_o,
  output logic [TRACK_BITS+1:0]               total_movement_o,
  output logic                                none_served_o,
  output logic                                overflow_seen_o
);
  import cscan_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_REQUESTS);
  localparam int unsigned CNT_W  = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned MOVE_W = TRACK_BITS + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EDGE1,
    ST_EDGE2,
    ST_ACC
  } state_e;

  state_e                  state_q;
  logic [TRACK_BITS-1:0]   start_head_q;
  logic [TRACK_BITS:0]     disk_tracks_q;
  logic                    sweep_up_q;
  logic [CNT_W-1:0]        count_q;
  logic                    dropped_q;
  logic [CNT_W-1:0]        done_q;
  logic [CNT_W-1:0]        scan_q;
  logic                    rvalid_q;
  logic [IDX_W-1:0]        ridx_q;
  logic [MAX_REQUESTS-1:0] served_q;
  logic                    best_found_q;
  logic                    best_grp_q;
  logic [TRACK_BITS-1:0]   best_trk_q;
  logic [IDX_W-1:0]        best_idx_q;
  logic                    edge_done_q;
  logic                    pending_q;
  logic [TRACK_BITS-1:0]   head_q;
  logic [MOVE_W-1:0]       acc_q;
  logic [MOVE_W-1:0]       acc_d;

  logic                    result_valid_q;
  logic [TRACK_BITS-1:0]   served_track_q;
  logic                    last_of_run_q;
  logic [MOVE_W-1:0]       total_movement_q;
  logic                    none_served_q;
  logic                    overflow_seen_q;

  logic                    accept;
  logic                    load_we;
  logic                    rd_en;
  logic [TRACK_BITS-1:0]   rdata;
  logic                    cand_grp;
  logic                    cand_better;
  logic                    cand_take;
  logic                    scan_done;
  logic                    final_item;
  logic                    second_grp;
  logic [TRACK_BITS-1:0]   top;
  logic [TRACK_BITS-1:0]   op_a;
  logic [TRACK_BITS-1:0]   op_b;
  logic [TRACK_BITS-1:0]   diff;
  logic [MOVE_W:0]         sum;

  assign accept  = start && (state_q == ST_IDLE);
  assign busy    = (state_q != ST_IDLE);
  assign load_we = accept && (command_i == CMD_LOAD) &&
                   (count_q < CNT_W'(MAX_REQUESTS));
  assign rd_en   = (state_q == ST_SCAN) && (scan_q < count_q);

  cscan_store #(
    .DEPTH (MAX_REQUESTS),
    .WIDTH (TRACK_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (track_i),
    .re_i    (rd_en),
    .raddr_i (scan_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  // The sort key is {track at or below the start head, track}: sweeping up
  // serves keys in ascending order, sweeping down in descending order.
  always_comb begin
    cand_grp    = (rdata <= start_head_q);
    cand_better = sweep_up_q ? ({cand_grp, rdata} < {best_grp_q, best_trk_q})
                             : ({cand_grp, rdata} > {best_grp_q, best_trk_q});
    cand_take   = rvalid_q && !served_q[ridx_q] && (!best_found_q || cand_better);
    scan_done   = (state_q == ST_SCAN) && !rd_en && !rvalid_q;
    final_item  = (done_q == count_q - CNT_W'(1));
    second_grp  = sweep_up_q ? best_grp_q : !best_grp_q;
  end

  // Last track of the disk after clamping the size to 1 .. 2^TRACK_BITS.
  always_comb begin
    if (disk_tracks_q == '0) begin
      top = '0;
    end else if (disk_tracks_q[TRACK_BITS]) begin
      top = '1;
    end else begin
      top = disk_tracks_q[TRACK_BITS-1:0] - TRACK_BITS'(1);
    end
  end

  // Shared unit: acc + |a - b|, saturating.
  always_comb begin
    case (state_q)
      ST_EDGE1: begin
        op_a = sweep_up_q ? top : head_q;
        op_b = sweep_up_q ? head_q : '0;
      end
      ST_EDGE2: begin
        op_a = top;
        op_b = '0;
      end
      default: begin
        op_a = best_trk_q;
        op_b = head_q;
      end
    endcase
    diff  = (op_a > op_b) ? (op_a - op_b) : (op_b - op_a);
    sum   = {1'b0, acc_q} + (MOVE_W + 1)'(diff);
    acc_d = sum[MOVE_W] ? '1 : sum[MOVE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      start_head_q     <= '0;
      disk_tracks_q    <= {1'b1, {TRACK_BITS{1'b0}}};
      sweep_up_q       <= 1'b1;
      count_q          <= '0;
      dropped_q        <= 1'b0;
      done_q           <= '0;
      scan_q           <= '0;
      rvalid_q         <= 1'b0;
      ridx_q           <= '0;
      served_q         <= '0;
      best_found_q     <= 1'b0;
      best_grp_q       <= 1'b0;
      best_trk_q       <= '0;
      best_idx_q       <= '0;
      edge_done_q      <= 1'b0;
      pending_q        <= 1'b0;
      head_q           <= '0;
      acc_q            <= '0;
      result_valid_q   <= 1'b0;
      served_track_q   <= '0;
      last_of_run_q    <= 1'b0;
      total_movement_q <= '0;
      none_served_q    <= 1'b0;
      overflow_seen_q  <= 1'b0;
    end else begin
      result_valid_q <= 1'b0;
      rvalid_q       <= rd_en;
      ridx_q         <= scan_q[IDX_W-1:0];

      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_START_HEAD:  start_head_q  <= cfg_wdata_i[TRACK_BITS-1:0];
          CFG_DISK_TRACKS: disk_tracks_q <= cfg_wdata_i;
          CFG_SWEEP_UP:    sweep_up_q    <= cfg_wdata_i[0];
          default: ;
        endcase
      end

      if (rd_en) begin
        scan_q <= scan_q + CNT_W'(1);
      end
      if (cand_take) begin
        best_found_q <= 1'b1;
        best_grp_q   <= cand_grp;
        best_trk_q   <= rdata;
        best_idx_q   <= ridx_q;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (command_i == CMD_LOAD) begin
              if (load_we) begin
                count_q <= count_q + CNT_W'(1);
              end else begin
                dropped_q <= 1'b1;
              end
            end else if (count_q == '0) begin
              result_valid_q   <= 1'b1;
              served_track_q   <= '0;
              last_of_run_q    <= 1'b1;
              total_movement_q <= '0;
              none_served_q    <= 1'b1;
              overflow_seen_q  <= dropped_q;
              dropped_q        <= 1'b0;
            end else begin
              state_q      <= ST_SCAN;
              served_q     <= '0;
              done_q       <= '0;
              scan_q       <= '0;
              best_found_q <= 1'b0;
              edge_done_q  <= 1'b0;
              pending_q    <= 1'b0;
              head_q       <= start_head_q;
              acc_q        <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state_q <= (second_grp && !edge_done_q) ? ST_EDGE1 : ST_ACC;
          end
        end
        ST_EDGE1: begin
          acc_q   <= acc_d;
          state_q <= ST_EDGE2;
        end
        ST_EDGE2: begin
          acc_q       <= acc_d;
          head_q      <= sweep_up_q ? '0 : top;
          edge_done_q <= 1'b1;
          if (pending_q) begin
            // The edge was still owed when the final track was reached.
            result_valid_q   <= 1'b1;
            served_track_q   <= best_trk_q;
            last_of_run_q    <= 1'b1;
            total_movement_q <= acc_d;
            none_served_q    <= 1'b0;
            overflow_seen_q  <= dropped_q;
            count_q          <= '0;
            dropped_q        <= 1'b0;
            state_q          <= ST_IDLE;
          end else begin
            state_q <= ST_ACC;
          end
        end
        ST_ACC: begin
          acc_q                <= acc_d;
          head_q               <= best_trk_q;
          served_q[best_idx_q] <= 1'b1;
          done_q               <= done_q + CNT_W'(1);
          if (final_item && !edge_done_q) begin
            pending_q <= 1'b1;
            state_q   <= ST_EDGE1;
          end else begin
            result_valid_q   <= 1'b1;
            served_track_q   <= best_trk_q;
            last_of_run_q    <= final_item;
            total_movement_q <= final_item ? acc_d : '0;
            none_served_q    <= 1'b0;
            overflow_seen_q  <= dropped_q;
            if (final_item) begin
              count_q   <= '0;
              dropped_q <= 1'b0;
              state_q   <= ST_IDLE;
            end else begin
              scan_q       <= '0;
              best_found_q <= 1'b0;
              state_q      <= ST_SCAN;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_valid_o   = result_valid_q;
  assign served_track_o   = served_track_q;
  assign last_of_run_o    = last_of_run_q;
  assign total_movement_o = total_movement_q;
  assign none_served_o    = none_served_q;
  assign overflow_seen_o  = overflow_seen_q;

endmodule

/* rtl/cscan_store.sv */
// Request store of the scheduler: one write port and one read port with
// registered read data. No dependencies.
module cscan_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the C-SCAN disk scheduler: load and start words,
// register writes, and a scoreboard that predicts the serving order and head travel.
// Depends on cscan_pkg and cscan_disk_scheduler.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cscan_pkg::*;

  localparam int unsigned MAX_REQUESTS  = 64;
  localparam int unsigned TRACK_BITS    = 16;
  localparam longint unsigned MOVE_MAX  = (64'd1 << (TRACK_BITS + 2)) - 1;
  localparam longint unsigned DISK_MAX  = 64'd1 << TRACK_BITS;
  localparam int unsigned QUIET_LIMIT   = 1000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned RANDOM_WORDS  = 85;

  typedef struct packed {
    logic [TRACK_BITS-1:0] track;
    logic                  last;
    logic [TRACK_BITS+1:0] movement;
    logic                  none;
    logic                  overflow;
  } served_word_t;

  class cscan_scoreboard;
    logic [TRACK_BITS-1:0] head_reg;
    logic [TRACK_BITS:0]   tracks_reg;
    logic                  up_reg;
    logic [TRACK_BITS-1:0] request_q[$];
    logic                  dropped;
    served_word_t          expected_q[$];
    longint unsigned       run_head;
    longint unsigned       run_travel;
    int unsigned           mismatches;
    int unsigned           results_seen;

    function new();
      head_reg     = '0;
      tracks_reg   = (TRACK_BITS + 1)'(DISK_MAX);
      up_reg       = 1'b1;
      dropped      = 1'b0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [TRACK_BITS:0] value);
      case (idx)
        CFG_START_HEAD:  head_reg = value[TRACK_BITS-1:0];
        CFG_DISK_TRACKS: tracks_reg = value;
        CFG_SWEEP_UP:    up_reg = value[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Moves the head to one track, adds the distance and queues the word.
    function void serve_track(logic [TRACK_BITS-1:0] trk);
      served_word_t    w;
      longint unsigned pos;
      pos = 64'(trk);
      run_travel += (pos > run_head) ? pos - run_head : run_head - pos;
      run_head = pos;
      w = '0;
      w.track = trk;
      w.overflow = dropped;
      expected_q.push_back(w);
    endfunction

    function void note_word(cmd_e cmd, logic [TRACK_BITS-1:0] trk);
      logic [TRACK_BITS-1:0] order [MAX_REQUESTS];
      logic [TRACK_BITS-1:0] pick;
      served_word_t          w;
      int                    n, split, i, j;
      longint unsigned       size, top;
      if (cmd == CMD_LOAD) begin
        if (request_q.size() < MAX_REQUESTS) request_q.push_back(trk);
        else dropped = 1'b1;
        return;
      end
      n = request_q.size();
      if (n == 0) begin
        w = '0;
        w.last = 1'b1;
        w.none = 1'b1;
        w.overflow = dropped;
        expected_q.push_back(w);
      end else begin
        for (i = 0; i < n; i++) begin
          pick = request_q[i];
          j = i;
          while (j > 0 && order[j-1] > pick) begin
            order[j] = order[j-1];
            j--;
          end
          order[j] = pick;
        end
        size = 64'(tracks_reg);
        if (size == 0) size = 1;
        if (size > DISK_MAX) size = DISK_MAX;
        top = size - 1;
        run_head = 64'(head_reg);
        run_travel = 0;
        // First track strictly above the head; tracks at the head count as below.
        split = 0;
        while (split < n && 64'(order[split]) <= run_head) split++;
        if (up_reg) begin
          for (i = split; i < n; i++) serve_track(order[i]);
          run_travel += ((top > run_head) ? top - run_head : run_head - top) + top;
          run_head = 0;
          for (i = 0; i < split; i++) serve_track(order[i]);
        end else begin
          for (i = split; i > 0; i--) serve_track(order[i-1]);
          run_travel += run_head + top;
          run_head = top;
          for (i = n; i > split; i--) serve_track(order[i-1]);
        end
        w = expected_q.pop_back();
        w.last = 1'b1;
        w.movement = (TRACK_BITS + 2)'((run_travel > MOVE_MAX) ? MOVE_MAX : run_travel);
        expected_q.push_back(w);
      end
      request_q.delete();
      dropped = 1'b0;
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(served_word_t got);
      served_word_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word, served_track", got.track, 0);
        return;
      end
      want = expected_q.pop_front();
      if (got.track !== want.track) report_mismatch("served_track", got.track, want.track);
      if (got.last !== want.last) report_mismatch("last_of_run", got.last, want.last);
      if (got.movement !== want.movement)
        report_mismatch("total_movement", got.movement, want.movement);
      if (got.none !== want.none) report_mismatch("none_served", got.none, want.none);
      if (got.overflow !== want.overflow)
        report_mismatch("overflow_seen", got.overflow, want.overflow);
    endtask
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    command_i = 1'b0;
  logic [TRACK_BITS-1:0]   track_i = '0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i = '0;
  logic [TRACK_BITS:0]     cfg_wdata_i = '0;
  logic                    result_valid_o;
  logic [TRACK_BITS-1:0]   served_track_o;
  logic                    last_of_run_o;
  logic [TRACK_BITS+1:0]   total_movement_o;
  logic                    none_served_o;
  logic                    overflow_seen_o;

  cscan_scoreboard sb;
  bit              steady_sender;
  int unsigned     words_sent;
  int unsigned     runs_started;
  int unsigned     cfg_writes;
  int unsigned     quiet_cycles;

  cscan_disk_scheduler #(
    .MAX_REQUESTS(MAX_REQUESTS),
    .TRACK_BITS  (TRACK_BITS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .track_i         (track_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .result_valid_o  (result_valid_o),
    .served_track_o  (served_track_o),
    .last_of_run_o   (last_of_run_o),
    .total_movement_o(total_movement_o),
    .none_served_o   (none_served_o),
    .overflow_seen_o (overflow_seen_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_result({served_track_o, last_of_run_o, total_movement_o,
                       none_served_o, overflow_seen_o});
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Each call starts on the cycle after the previous word was taken, so start is
  // either lowered for the gap or carries the next word straight away.
  task automatic send_word(cmd_e cmd, logic [TRACK_BITS-1:0] trk);
    int unsigned gap;
    gap = steady_sender ? 0 : $urandom_range(0, 15);
    @(negedge clk_i);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    command_i <= cmd;
    track_i <= trk;
    do @(posedge clk_i); while (busy);
    sb.note_word(cmd, trk);
    words_sent++;
    if (cmd == CMD_START) runs_started++;
  endtask

  // Lowers start and waits until every queued word has come back.
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [TRACK_BITS:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_register(idx, value);
    cfg_writes++;
  endtask

  task automatic configure_random();
    logic [TRACK_BITS-1:0] head;
    logic [TRACK_BITS:0]   tracks;
    case ($urandom_range(0, 3))
      0:       head = '0;
      1:       head = '1;
      default: head = TRACK_BITS'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0:       tracks = '0;
      1:       tracks = 1;
      2:       tracks = (TRACK_BITS + 1)'($urandom_range(2, 300));
      3:       tracks = (TRACK_BITS + 1)'(DISK_MAX);
      4:       tracks = (TRACK_BITS + 1)'($urandom_range(DISK_MAX + 1, 2 * DISK_MAX - 1));
      default: tracks = (TRACK_BITS + 1)'($urandom_range(1, DISK_MAX - 1));
    endcase
    write_register(CFG_START_HEAD, head);
    write_register(CFG_DISK_TRACKS, tracks);
    write_register(CFG_SWEEP_UP, (TRACK_BITS + 1)'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) == 0) write_register(CFG_UNUSED, (TRACK_BITS + 1)'($urandom));
  endtask

  // Mixes tracks near the head, near both ends, repeats and values off the disk.
  function automatic logic [TRACK_BITS-1:0] pick_track(logic [TRACK_BITS-1:0] prev);
    logic [TRACK_BITS-1:0] trk;
    case ($urandom_range(0, 5))
      0:       trk = sb.head_reg + TRACK_BITS'($urandom_range(0, 6)) - TRACK_BITS'(3);
      1:       trk = prev;
      2:       trk = $urandom_range(0, 3);
      3:       trk = '1 - TRACK_BITS'($urandom_range(0, 3));
      4:       trk = TRACK_BITS'($urandom % (sb.tracks_reg + 1));
      default: trk = TRACK_BITS'($urandom);
    endcase
    return trk;
  endfunction

  initial begin
    int unsigned           random_words;
    int unsigned           loads;
    logic [TRACK_BITS-1:0] prev;
    bit                    filled;
    sb = new();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: an empty start, then both track extremes with a repeat.
    steady_sender = 1'b0;
    send_word(CMD_START, '0);
    send_word(CMD_LOAD, '1);
    send_word(CMD_LOAD, '0);
    send_word(CMD_LOAD, '0);
    send_word(CMD_START, '1);
    settle();

    // Downward sweep on a small disk: a track at the head, one past the disk,
    // then runs with nothing above and with nothing at or below the head.
    write_register(CFG_START_HEAD, 100);
    write_register(CFG_DISK_TRACKS, 200);
    write_register(CFG_SWEEP_UP, 0);
    send_word(CMD_LOAD, 100);
    send_word(CMD_LOAD, 50);
    send_word(CMD_LOAD, 300);
    send_word(CMD_LOAD, 150);
    send_word(CMD_START, 0);
    send_word(CMD_LOAD, 5);
    send_word(CMD_LOAD, 7);
    send_word(CMD_START, 0);
    send_word(CMD_LOAD, 180);
    send_word(CMD_START, 0);
    settle();

    // Zero disk size is taken as one track; upward with nothing above the head.
    write_register(CFG_START_HEAD, '1);
    write_register(CFG_DISK_TRACKS, '0);
    write_register(CFG_SWEEP_UP, 1);
    write_register(CFG_UNUSED, '1);
    send_word(CMD_LOAD, '1);
    send_word(CMD_LOAD, 1);
    send_word(CMD_START, 0);
    settle();

    // Oversized disk value is clamped to the full track range.
    write_register(CFG_START_HEAD, '0);
    write_register(CFG_DISK_TRACKS, '1);
    write_register(CFG_SWEEP_UP, 0);
    send_word(CMD_LOAD, '0);
    send_word(CMD_LOAD, '1);
    send_word(CMD_START, 0);

    // Random phases; the first run overfills the store so loads get dropped.
    filled = 1'b0;
    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      settle();
      configure_random();
      repeat ($urandom_range(1, 3)) begin
        steady_sender = ($urandom_range(0, 2) == 0);
        loads = filled ? $urandom_range(0, 9)
                       : $urandom_range(MAX_REQUESTS + 1, MAX_REQUESTS + 4);
        filled = 1'b1;
        prev = TRACK_BITS'($urandom);
        repeat (loads) begin
          prev = pick_track(prev);
          send_word(CMD_LOAD, prev);
        end
        send_word(CMD_START, TRACK_BITS'($urandom));
        random_words += loads + 1;
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d words in %0d scheduling runs with %0d register writes;",
             words_sent, runs_started, cfg_writes);
    $display("checked %0d served-track words, %0d mismatches.",
             sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
